// File: hw/rtl/upn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// upn_pkg: shared types and constants of the URL path normalizer
// Result item layout, the per-transaction push bundle and the step state.
// ---------------------------------------------------------------------------
package upn_pkg;

    localparam int MAX_RES = 4;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int PUSH_W  = $clog2(MAX_RES + 1);

    // Result queue; the depth must be a power of two.
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_SL   = 8'h2F;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] HEX_TEN = 8'd10;
    localparam logic [2:0] LEN_MAX = 3'd7;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HIGH = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       in_query;
        logic       out_last;
    } t_result;

    typedef struct packed {
        logic [PUSH_W-1:0]             n;
        t_result [MAX_RES-1:0]         res;
    } t_push;

    typedef struct packed {
        logic [15:0] raw_window;
        logic [1:0]  raw_count;
        logic [1:0]  esc_phase;
        logic [7:0]  esc_high;
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        logic [2:0]  path_length;
        logic        query_mode;
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/upn_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// upn_if: valid/ready channels of the URL path normalizer
// One interface for input bytes and one for result items.
// ---------------------------------------------------------------------------
interface upn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_query;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output in_query,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input in_query,
                    input out_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/upn_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// upn_core: input register and combinational normalizing step
// Holds one input byte, computes all of its result items and the next state
// in one pass, and hands the results to the queue when it has room.
// ---------------------------------------------------------------------------
module upn_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_ready,
    input  logic          i_room,
    output upn_pkg::t_push o_push
);
    import upn_pkg::*;

    typedef struct packed {
        t_state                st;
        t_result [MAX_RES-1:0] res;
        logic [PUSH_W-1:0]     n;
    } t_work;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_work      w_work;
    logic       w_proc;

    function automatic t_work put_res(t_work w, logic [7:0] b, logic has, logic q);
        t_work r;
        r = w;
        if (r.n < PUSH_W'(MAX_RES)) begin
            r.res[r.n[RES_IW-1:0]].out_byte = b;
            r.res[r.n[RES_IW-1:0]].has_byte = has;
            r.res[r.n[RES_IW-1:0]].in_query = q;
            r.res[r.n[RES_IW-1:0]].out_last = 1'b0;
            r.n = r.n + PUSH_W'(1);
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_val(logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CH_LA && c <= CH_LZ) u = c - CH_LA + CH_A;
        if (u >= CH_A) return u - CH_A + HEX_TEN;
        return c - CH_0;
    endfunction

    // Holds back a '.' that may turn out to be the start of "./" or the
    // end of "/." until the following byte or the end of the path decides.
    function automatic t_work hold_push(t_work w, logic [7:0] b);
        t_work      r;
        logic [7:0] prev;
        logic       taken;
        r     = w;
        taken = 1'b0;
        if (r.st.held_count == 2'd2) begin
            r = put_res(r, r.st.held_bytes[7:0], 1'b1, 1'b0);
            r.st.held_count  = 2'd0;
            r.st.path_length = 3'd1;
        end else if (r.st.held_count == 2'd1) begin
            if (r.st.path_length == 3'd1 && b == CH_SL) begin
                r.st.held_bytes  = {r.st.held_bytes[7:0], b};
                r.st.held_count  = 2'd2;
                r.st.path_length = 3'd2;
                taken = 1'b1;
            end else begin
                r = put_res(r, r.st.held_bytes[7:0], 1'b1, 1'b0);
                r.st.held_count = 2'd0;
            end
        end
        if (!taken) begin
            prev = r.st.held_bytes[7:0];
            r.st.held_bytes = {r.st.held_bytes[7:0], b};
            if (r.st.path_length < LEN_MAX) r.st.path_length = r.st.path_length + 3'd1;
            if (r.st.path_length == 3'd1 && b == CH_DOT) begin
                r.st.held_count = 2'd1;
            end else if (r.st.path_length >= 3'd2 && prev == CH_SL && b == CH_DOT) begin
                r.st.held_count = 2'd1;
            end else begin
                r = put_res(r, b, 1'b1, 1'b0);
            end
        end
        return r;
    endfunction

    function automatic t_work deliver(t_work w, logic [7:0] v, logic q);
        if (q) return put_res(w, v, 1'b1, 1'b1);
        return hold_push(w, v);
    endfunction

    function automatic t_work decode(t_work w, logic [7:0] c, logic q);
        t_work      r;
        logic [7:0] hh;
        logic [7:0] hl;
        r  = w;
        hh = hex_val(r.st.esc_high);
        hl = hex_val(c);
        priority if (r.st.esc_phase == ESC_PCT) begin
            r.st.esc_high  = c;
            r.st.esc_phase = ESC_HIGH;
        end else if (r.st.esc_phase == ESC_HIGH) begin
            r = deliver(r, (hh << 4) + hl, q);
            r.st.esc_phase = ESC_IDLE;
        end else if (c == CH_PCT) begin
            r.st.esc_phase = ESC_PCT;
        end else begin
            r = deliver(r, c, q);
        end
        return r;
    endfunction

    // An escape cut short by the end of its section passes its one digit on.
    function automatic t_work decode_flush(t_work w, logic q);
        t_work r;
        r = w;
        if (r.st.esc_phase == ESC_HIGH) r = deliver(r, r.st.esc_high, q);
        r.st.esc_phase = ESC_IDLE;
        return r;
    endfunction

    function automatic t_work raw_push(t_work w, logic [7:0] x);
        t_work      r;
        logic [7:0] w0;
        logic [7:0] w1;
        r  = w;
        w0 = r.st.raw_window[7:0];
        w1 = r.st.raw_window[15:8];
        if (r.st.raw_count < 2'd2) begin
            if (r.st.raw_count == 2'd0) r.st.raw_window[7:0]  = w0 | x;
            else                        r.st.raw_window[15:8] = w1 | x;
            r.st.raw_count = r.st.raw_count + 2'd1;
        end else if (w0 == CH_SL && w1 == CH_DOT && x == CH_SL) begin
            r.st.raw_window = {8'h00, x};
            r.st.raw_count  = 2'd1;
        end else begin
            if (!(w0 == CH_SL && w1 == CH_SL)) r = decode(r, w0, 1'b0);
            r.st.raw_window = {x, w1};
        end
        return r;
    endfunction

    function automatic t_work hold_flush(t_work w);
        t_work r;
        r = w;
        if (r.st.held_count == 2'd2) begin
            r = put_res(r, r.st.held_bytes[15:8], 1'b1, 1'b0);
            r = put_res(r, r.st.held_bytes[7:0], 1'b1, 1'b0);
        end else if (r.st.held_count == 2'd1 && r.st.path_length <= 3'd2) begin
            r = put_res(r, r.st.held_bytes[7:0], 1'b1, 1'b0);
        end
        r.st.held_count = 2'd0;
        return r;
    endfunction

    function automatic t_work path_flush(t_work w);
        t_work      r;
        logic [7:0] w0;
        logic [7:0] w1;
        r  = w;
        w0 = r.st.raw_window[7:0];
        w1 = r.st.raw_window[15:8];
        if (r.st.raw_count == 2'd2) begin
            if (!(w0 == CH_SL && w1 == CH_SL)) r = decode(r, w0, 1'b0);
            r = decode(r, w1, 1'b0);
        end else if (r.st.raw_count == 2'd1) begin
            r = decode(r, w0, 1'b0);
        end
        r.st.raw_window = '0;
        r.st.raw_count  = 2'd0;
        r = decode_flush(r, 1'b0);
        r = hold_flush(r);
        return r;
    endfunction

    function automatic t_work step(t_state s, logic [7:0] b, logic last);
        t_work w;
        w    = '0;
        w.st = s;
        if (s.query_mode) begin
            w = decode(w, b, 1'b1);
        end else if (b == CH_QM) begin
            w = path_flush(w);
            w.st.query_mode = 1'b1;
        end else begin
            w = raw_push(w, b);
        end
        if (last) begin
            if (w.st.query_mode) w = decode_flush(w, 1'b1);
            else                 w = path_flush(w);
            // A target that ends without a byte still gets an end marker.
            if (w.n == '0) w = put_res(w, 8'h00, 1'b0, w.st.query_mode);
            w.res[RES_IW'(w.n - PUSH_W'(1))].out_last = 1'b1;
            w.st = '0;
        end
        return w;
    endfunction

    always_comb begin
        w_work     = step(r_state, r_in_byte, r_in_last);
        w_proc     = r_in_valid && i_room;
        o_ready    = !r_in_valid || i_room;
        o_push.n   = w_proc ? w_work.n : '0;
        o_push.res = w_work.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (w_proc)  r_state    <= w_work.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/upn_rfifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// upn_rfifo: result queue
// Takes up to four result items per cycle and presents one per transaction.
// ---------------------------------------------------------------------------
module upn_rfifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  upn_pkg::t_push               i_push,
    input  logic                         i_pop,
    output upn_pkg::t_result             o_head,
    output logic                         o_valid,
    output logic [upn_pkg::Q_CW-1:0]     o_count
);
    import upn_pkg::*;

    t_result           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (PUSH_W'(k) < i_push.n) begin
                r_mem[r_wr_ptr + Q_AW'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_AW'(i_push.n);
            r_rd_ptr <= r_rd_ptr + Q_AW'(i_pop);
            r_count  <= r_count + Q_CW'(i_push.n) - Q_CW'(i_pop);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/url_path_normalizer_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// url_path_normalizer_unit: request target path normalizer and decoder
// Bytes are taken one per cycle while the result queue has room; the input
// register holds a byte until its results are written into the queue.
// A byte gives up to four results, which leave one per cycle while the output
// is ready, through an eight-entry result queue; a byte waits in the input
// register while fewer than four queue entries are free.
// Reset is synchronous, active low, and clears the step state and the queue.
// ---------------------------------------------------------------------------
module url_path_normalizer_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    upn_in_if.sink   i_in,
    upn_out_if.source o_out
);
    import upn_pkg::*;

    t_push            w_push;
    t_result          w_head;
    logic             w_valid;
    logic             w_pop;
    logic             w_room;
    logic [Q_CW-1:0]  w_count;

    assign w_room = (w_count <= Q_CW'(Q_DEPTH - MAX_RES));
    assign w_pop  = w_valid && o_out.ready;

    upn_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .o_ready (i_in.ready),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    upn_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_valid (w_valid),
        .o_count (w_count)
    );

    assign o_out.valid    = w_valid;
    assign o_out.out_byte = w_head.out_byte;
    assign o_out.has_byte = w_head.has_byte;
    assign o_out.in_query = w_head.in_query;
    assign o_out.out_last = w_head.out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= Q_CW'(Q_DEPTH))
        else $error("result queue holds more entries than its depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.n != '0) |-> w_room)
        else $error("results pushed without room for a full transaction");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> w_count == $past(w_count) + Q_CW'($past(w_push.n)) - Q_CW'($past(w_pop)))
        else $error("result queue count does not follow pushes and pops");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for url_path_normalizer_unit
// Request targets, some hand-picked and the rest random, are streamed into
// the block in bursts while the result side stalls on changing patterns.
// A scoreboard predicts every result item and checks each one on arrival.
// ---------------------------------------------------------------------------
module tb_top;
    import upn_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_BYTES = 385;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } byte_item_t;

    class path_scoreboard;
        logic [15:0] raw_win;
        logic [1:0]  raw_n;
        logic [1:0]  esc;
        logic [7:0]  esc_hi;
        logic [15:0] kept;
        logic [1:0]  kept_n;
        logic [2:0]  plen;
        logic        qmode;
        t_result     step_res[$];
        t_result     expected_out[$];
        int          errors;
        int          printed;
        int          n_bytes;
        int          n_targets;
        int          n_results;
        int          n_query;
        int          n_empty;

        function new();
            clear_state();
            errors    = 0;
            printed   = 0;
            n_bytes   = 0;
            n_targets = 0;
            n_results = 0;
            n_query   = 0;
            n_empty   = 0;
        endfunction

        function void clear_state();
            raw_win = '0;
            raw_n   = '0;
            esc     = ESC_IDLE;
            esc_hi  = '0;
            kept    = '0;
            kept_n  = '0;
            plen    = '0;
            qmode   = 1'b0;
        endfunction

        task report(string msg);
            errors++;
            if (printed < 30) begin
                printed++;
                $display("ERROR: %s", msg);
            end
        endtask

        function void emit(logic [7:0] b, logic has, logic q);
            t_result r;
            if (step_res.size() < MAX_RES) begin
                r.out_byte = b;
                r.has_byte = has;
                r.in_query = q;
                r.out_last = 1'b0;
                step_res.push_back(r);
            end
        endfunction

        // Hex digits are not validated; anything at or above 'A' counts as a letter.
        function logic [7:0] hex_digit(logic [7:0] c);
            logic [7:0] u;
            u = c;
            if (c >= CH_LA && c <= CH_LZ) u = c - CH_LA + CH_A;
            if (u >= CH_A) return u - CH_A + HEX_TEN;
            return c - CH_0;
        endfunction

        // A lone '.' at the start or after '/' is held back until the next
        // byte shows whether it may be dropped.
        function void keep_path_byte(logic [7:0] b);
            logic [7:0] prev;
            if (kept_n == 2'd2) begin
                emit(kept[7:0], 1'b1, 1'b0);
                kept_n = 2'd0;
                plen   = 3'd1;
            end else if (kept_n == 2'd1) begin
                if (plen == 3'd1 && b == CH_SL) begin
                    kept   = {kept[7:0], b};
                    kept_n = 2'd2;
                    plen   = 3'd2;
                    return;
                end
                emit(kept[7:0], 1'b1, 1'b0);
                kept_n = 2'd0;
            end
            prev = kept[7:0];
            kept = {kept[7:0], b};
            if (plen < LEN_MAX) plen++;
            if (plen == 3'd1 && b == CH_DOT) kept_n = 2'd1;
            else if (plen >= 3'd2 && prev == CH_SL && b == CH_DOT) kept_n = 2'd1;
            else emit(b, 1'b1, 1'b0);
        endfunction

        function void deliver(logic [7:0] v, logic q);
            if (q) emit(v, 1'b1, 1'b1);
            else keep_path_byte(v);
        endfunction

        function void unescape(logic [7:0] c, logic q);
            case (esc)
                ESC_PCT: begin
                    esc_hi = c;
                    esc    = ESC_HIGH;
                end
                ESC_HIGH: begin
                    deliver((hex_digit(esc_hi) << 4) + hex_digit(c), q);
                    esc = ESC_IDLE;
                end
                default: begin
                    if (c == CH_PCT) esc = ESC_PCT;
                    else deliver(c, q);
                end
            endcase
        endfunction

        function void unescape_flush(logic q);
            if (esc == ESC_HIGH) deliver(esc_hi, q);
            esc = ESC_IDLE;
        endfunction

        function void close_path();
            if (raw_n == 2'd2) begin
                if (!(raw_win[7:0] == CH_SL && raw_win[15:8] == CH_SL))
                    unescape(raw_win[7:0], 1'b0);
                unescape(raw_win[15:8], 1'b0);
            end else if (raw_n == 2'd1) begin
                unescape(raw_win[7:0], 1'b0);
            end
            raw_win = '0;
            raw_n   = '0;
            unescape_flush(1'b0);
            if (kept_n == 2'd2) begin
                emit(kept[15:8], 1'b1, 1'b0);
                emit(kept[7:0], 1'b1, 1'b0);
            end else if (kept_n == 2'd1) begin
                if (plen <= 3'd2) emit(kept[7:0], 1'b1, 1'b0);
            end
            kept_n = 2'd0;
        endfunction

        // Works out the results that one accepted byte transaction causes.
        function void note_byte(byte_item_t it);
            t_result r;
            step_res.delete();
            n_bytes++;
            if (qmode) begin
                unescape(it.b, 1'b1);
            end else if (it.b == CH_QM) begin
                close_path();
                qmode = 1'b1;
            end else if (raw_n < 2'd2) begin
                raw_win = raw_win | ({8'h00, it.b} << (8 * raw_n));
                raw_n++;
            end else if (raw_win[7:0] == CH_SL && raw_win[15:8] == CH_DOT && it.b == CH_SL) begin
                raw_win = {8'h00, it.b};
                raw_n   = 2'd1;
            end else begin
                if (!(raw_win[7:0] == CH_SL && raw_win[15:8] == CH_SL))
                    unescape(raw_win[7:0], 1'b0);
                raw_win = {it.b, raw_win[15:8]};
            end
            if (it.last) begin
                if (qmode) unescape_flush(1'b1);
                else close_path();
                if (step_res.size() == 0) emit(8'h00, 1'b0, qmode);
                r = step_res.pop_back();
                r.out_last = 1'b1;
                step_res.push_back(r);
                clear_state();
                n_targets++;
            end
            foreach (step_res[i]) begin
                if (step_res[i].in_query) n_query++;
                if (!step_res[i].has_byte) n_empty++;
                expected_out.push_back(step_res[i]);
            end
        endfunction

        task check_result(t_result got);
            t_result want;
            n_results++;
            if (expected_out.size() == 0) begin
                report($sformatf("result with nothing pending: byte %02h has %b query %b last %b",
                                 got.out_byte, got.has_byte, got.in_query, got.out_last));
                return;
            end
            want = expected_out.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.in_query !== want.in_query || got.out_last !== want.out_last)
                report($sformatf("result %0d: got byte %02h has %b query %b last %b, want %02h %b %b %b",
                                 n_results, got.out_byte, got.has_byte, got.in_query, got.out_last,
                                 want.out_byte, want.has_byte, want.in_query, want.out_last));
        endtask

        task close_out();
            if (expected_out.size() != 0)
                report($sformatf("%0d expected results never arrived", expected_out.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic rst_done;

    upn_in_if  in_ch();
    upn_out_if out_ch();

    url_path_normalizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    path_scoreboard sb;
    byte_item_t     byte_q[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic add_target(string s);
        byte_item_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.b    = s[i];
            it.last = (i == s.len() - 1);
            byte_q.push_back(it);
        end
    endtask

    function automatic logic [7:0] pick_char();
        string hexset;
        int    r;
        hexset = "0123456789abcdefABCDEF";
        r = $urandom_range(0, 99);
        if (r < 24) return CH_SL;
        if (r < 40) return CH_DOT;
        if (r < 50) return CH_PCT;
        if (r < 54) return CH_QM;
        if (r < 74) return hexset[$urandom_range(0, hexset.len() - 1)];
        if (r < 86) return 8'($urandom_range(8'h67, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_random();
        byte_item_t it;
        int         count;
        int         len;
        count = 0;
        while (count < RAND_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                it.b    = (i == 0 && $urandom_range(0, 9) < 7) ? CH_SL : pick_char();
                it.last = (i == len - 1);
                byte_q.push_back(it);
            end
            count += len;
        end
    endtask

    // Sender: bursts of random length separated by random gaps. A byte stays
    // on the channel until its transaction completes.
    task automatic drive_bytes();
        int burst;
        int gap;
        burst = $urandom_range(1, 24);
        while (byte_q.size() > 0) begin
            in_ch.valid   = 1'b1;
            in_ch.in_byte = byte_q[0].b;
            in_ch.in_last = byte_q[0].last;
            do @(posedge i_clk); while (in_ch.ready !== 1'b1);
            sb.note_byte(byte_q.pop_front());
            @(negedge i_clk);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                if (gap > 0) begin
                    in_ch.valid   = 1'b0;
                    in_ch.in_byte = 8'($urandom);
                    in_ch.in_last = 1'($urandom);
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
        in_ch.valid = 1'b0;
    endtask

    // Receiver: ready follows a 16-bit pattern that is replaced now and then.
    initial begin
        logic [15:0] pattern;
        int          phase;
        int          mode;
        out_ch.ready = 1'b0;
        phase = 0;
        forever begin
            mode = $urandom_range(0, 3);
            case (mode)
                0:       pattern = 16'hFFFF;
                1:       pattern = 16'($urandom) & 16'($urandom);
                default: pattern = 16'($urandom);
            endcase
            pattern[0] = 1'b1;
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                out_ch.ready = pattern[phase];
                phase = (phase + 1) % 16;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (rst_done && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.out_byte = out_ch.out_byte;
            got.has_byte = out_ch.has_byte;
            got.in_query = out_ch.in_query;
            got.out_last = out_ch.out_last;
            sb.check_result(got);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("url_path_normalizer_unit: mismatch");
        $finish;
    end

    initial begin
        byte_item_t it;
        sb            = new();
        rst_done      = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        // Hand-picked targets: collapses, dot drops, escapes, short escapes,
        // empty ends in both sections, and the byte extremes.
        add_target("/./a");
        add_target("//%2e/");
        add_target("./x/.");
        add_target("%41?%6");
        add_target("?");
        add_target("%");
        it.b = 8'h00; it.last = 1'b0; byte_q.push_back(it);
        it.b = 8'hFF; it.last = 1'b1; byte_q.push_back(it);
        build_random();

        drive_bytes();
        while (sb.expected_out.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        sb.close_out();

        $display("Sent %0d targets in %0d bytes; checked %0d results,", sb.n_targets,
                 sb.n_bytes, sb.n_results);
        $display("%0d of them from query strings and %0d empty end markers.", sb.n_query,
                 sb.n_empty);
        if (sb.errors == 0)
            $display("url_path_normalizer_unit: match");
        else
            $display("url_path_normalizer_unit: mismatch");
        $finish;
    end
endmodule

// File: url_path_normalizer_unit.f
hw/rtl/upn_pkg.sv
hw/rtl/upn_if.sv
hw/rtl/upn_core.sv
hw/rtl/upn_rfifo.sv
hw/rtl/url_path_normalizer_unit.sv
test/tb_top.sv
